/* rtl/core/pid_pkg.sv */
// Package for the clamped PID controller: payload structs, register indexes,
// and the datapath widths shared by all stages.
// No dependencies.
package pid_pkg;

    // Datapath widths
    localparam int DataW  = 16;                 // target, measured, drive, registers
    localparam int GainW  = 16;                 // Q8.8 gains
    localparam int ErrW   = DataW + 1;          // target - measured
    localparam int DerW   = ErrW + 1;           // err - last err
    localparam int IntW   = 32;                 // saturating integral
    localparam int ProdPW = GainW + ErrW;
    localparam int ProdIW = GainW + IntW;
    localparam int ProdDW = GainW + DerW;
    localparam int AccW   = ProdIW + 2;         // sum of three products
    localparam int FracW  = 8;                  // Q8.8 fraction bits
    localparam int ScW    = AccW - FracW;       // accumulator after the shift
    localparam int CfgIdxW = 3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_OUT_MIN = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_OUT_MAX = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_P  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_I  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_D  = 3'd4;

    // Register reset values
    localparam logic signed [DataW-1:0] OUT_MIN_RST = -16'sd255;
    localparam logic signed [DataW-1:0] OUT_MAX_RST = 16'sd255;

    typedef struct packed {
        logic signed [DataW-1:0] target;
        logic signed [DataW-1:0] measured;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0] drive;
        logic                    integral_saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [DataW-1:0] out_min;
        logic signed [DataW-1:0] out_max;
        logic signed [GainW-1:0] gain_p;
        logic signed [GainW-1:0] gain_i;
        logic signed [GainW-1:0] gain_d;
    } t_cfg;

    // Error/integral stage to multiply stage
    typedef struct packed {
        logic signed [ErrW-1:0] err;
        logic signed [DerW-1:0] deriv;
        logic signed [IntW-1:0] integral;
        logic                   sat;
    } t_err_stage;

    // Multiply stage to output stage
    typedef struct packed {
        logic signed [ProdPW-1:0] prod_p;
        logic signed [ProdIW-1:0] prod_i;
        logic signed [ProdDW-1:0] prod_d;
        logic                     sat;
    } t_prod_stage;

endpackage

/* rtl/core/pid_cfg.sv */
// Configuration register file for the PID controller: limits and gains.
// Depends on pid_pkg.
module pid_cfg
    import pid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [DataW-1:0]   i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the write; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OUT_MIN: n_cfg.out_min = i_cfg_data;
                CFG_OUT_MAX: n_cfg.out_max = i_cfg_data;
                CFG_GAIN_P:  n_cfg.gain_p  = i_cfg_data;
                CFG_GAIN_I:  n_cfg.gain_i  = i_cfg_data;
                CFG_GAIN_D:  n_cfg.gain_d  = i_cfg_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.out_min <= OUT_MIN_RST;
            r_cfg.out_max <= OUT_MAX_RST;
            r_cfg.gain_p  <= '0;
            r_cfg.gain_i  <= '0;
            r_cfg.gain_d  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* rtl/core/pid_err_int.sv */
// Error stage: forms the error, updates the saturating integral and the
// previous error, and registers error, derivative and integral.
// Depends on pid_pkg.
module pid_err_int
    import pid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_err_stage o_data
);

    logic                   r_valid;
    t_err_stage             r_data;
    logic signed [IntW-1:0] r_integral;
    logic signed [ErrW-1:0] r_last_error;

    logic                   accept;
    logic signed [ErrW-1:0] err;
    logic signed [IntW:0]   sum_wide;
    logic                   sat;
    logic signed [IntW-1:0] n_integral;
    logic signed [DerW-1:0] deriv;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Error and derivative
    assign err   = {i_data.target[DataW-1], i_data.target}
                 - {i_data.measured[DataW-1], i_data.measured};
    assign deriv = {err[ErrW-1], err} - {r_last_error[ErrW-1], r_last_error};

    // Integral accumulate with saturation, then clear at zero target and error
    assign sum_wide = {r_integral[IntW-1], r_integral}
                    + {{(IntW + 1 - ErrW){err[ErrW-1]}}, err};
    assign sat      = sum_wide[IntW] != sum_wide[IntW-1];

    always_comb begin
        if (sat) begin
            n_integral = sum_wide[IntW] ? {1'b1, {(IntW-1){1'b0}}}
                                        : {1'b0, {(IntW-1){1'b1}}};
        end else begin
            n_integral = sum_wide[IntW-1:0];
        end
        if (i_data.target == '0 && err == '0) begin
            n_integral = '0;
        end
    end

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral   <= '0;
            r_last_error <= '0;
        end else if (accept) begin
            r_integral   <= n_integral;
            r_last_error <= err;
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data.err      <= err;
            r_data.deriv    <= deriv;
            r_data.integral <= n_integral;
            r_data.sat      <= sat;
        end
    end

endmodule

/* rtl/core/pid_mult.sv */
// Multiply stage: the three gain products, each registered.
// Depends on pid_pkg.
module pid_mult
    import pid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_err_stage  i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_prod_stage o_data
);

    logic        r_valid;
    t_prod_stage r_data;
    logic        accept;

    logic signed [GainW-1:0]  gp, gi, gd;
    logic signed [ErrW-1:0]   err;
    logic signed [IntW-1:0]   integ;
    logic signed [DerW-1:0]   deriv;
    logic signed [ProdPW-1:0] prod_p;
    logic signed [ProdIW-1:0] prod_i;
    logic signed [ProdDW-1:0] prod_d;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign gp    = i_cfg.gain_p;
    assign gi    = i_cfg.gain_i;
    assign gd    = i_cfg.gain_d;
    assign err   = i_data.err;
    assign integ = i_data.integral;
    assign deriv = i_data.deriv;

    // Signed products at full width
    assign prod_p = gp * err;
    assign prod_i = gi * integ;
    assign prod_d = gd * deriv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data.prod_p <= prod_p;
            r_data.prod_i <= prod_i;
            r_data.prod_d <= prod_d;
            r_data.sat    <= i_data.sat;
        end
    end

endmodule

/* rtl/core/pid_out.sv */
// Output stage: sums the products, drops the Q8.8 fraction (floor) and clamps
// to the configured limits into the result register.
// Depends on pid_pkg.
module pid_out
    import pid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_prod_stage i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data
);

    logic      r_valid;
    t_out_item r_data;
    logic      accept;

    logic signed [AccW-1:0]  acc;
    logic signed [ScW-1:0]   y;
    logic signed [ScW-1:0]   lo;
    logic signed [ScW-1:0]   hi;
    logic signed [DataW-1:0] drive;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Weighted sum; dropping the low bits is an arithmetic shift (floor)
    assign acc = {{(AccW - ProdPW){i_data.prod_p[ProdPW-1]}}, i_data.prod_p}
               + {{(AccW - ProdIW){i_data.prod_i[ProdIW-1]}}, i_data.prod_i}
               + {{(AccW - ProdDW){i_data.prod_d[ProdDW-1]}}, i_data.prod_d};
    assign y   = acc[AccW-1:FracW];

    assign lo = {{(ScW - DataW){i_cfg.out_min[DataW-1]}}, i_cfg.out_min};
    assign hi = {{(ScW - DataW){i_cfg.out_max[DataW-1]}}, i_cfg.out_max};

    // Clamp: the lower bound is checked first; with crossed limits a value below it gets out_min, any other out_max
    always_comb begin
        if (y < lo) begin
            drive = i_cfg.out_min;
        end else if (y > hi) begin
            drive = i_cfg.out_max;
        end else begin
            drive = y[DataW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data.drive              <= drive;
            r_data.integral_saturated <= i_data.sat;
        end
    end

endmodule

/* rtl/core/pid_controller_with_clamp.sv */
// Top level of the clamped positional PID controller.
// Depends on pid_pkg, pid_cfg, pid_err_int, pid_mult and pid_out.

// One sample per clock while no stall backs up the stages: a sample may be
// taken every cycle. Its result passes through the error/integral register,
// the product register and the result register, independent of the data. The
// integral and previous-error state is updated in the cycle a sample is
// accepted, so samples are processed strictly in order. A stalled output
// backs up the three stage registers before the input ready drops. Limits
// and gains are read live by the stages and should be written only while no
// samples are in flight.
module pid_controller_with_clamp
    import pid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [DataW-1:0]   i_cfg_data,
    // Sample input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    // Result output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out
);

    t_cfg        cfg;
    logic        err_valid, err_ready;
    t_err_stage  err_data;
    logic        prod_valid, prod_ready;
    t_prod_stage prod_data;

    pid_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pid_err_int u_err_int (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in),
        .o_valid (err_valid),
        .i_ready (err_ready),
        .o_data  (err_data)
    );

    pid_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (err_valid),
        .o_ready (err_ready),
        .i_data  (err_data),
        .o_valid (prod_valid),
        .i_ready (prod_ready),
        .o_data  (prod_data)
    );

    pid_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_data  (prod_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

endmodule

/* rtl/core/pid_checker.sv */
// Port-level checker for the clamped PID controller, bound to the top level.
// Depends on pid_pkg.
module pid_checker
    import pid_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // Transactions accepted but not yet delivered
    logic [1:0] r_pending;
    logic [1:0] n_pending;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (in_acc && !out_acc) begin
            n_pending = r_pending + 2'd1;
        end else if (out_acc && !in_acc) begin
            n_pending = r_pending - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // No result without an outstanding transaction
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 2'd0)
        else $error("result without a pending transaction");

    // At most three transactions in flight: input must stall when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 2'd3 && !out_acc |-> !o_in_ready)
        else $error("input accepted with pipeline full");

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind pid_controller_with_clamp pid_checker u_pid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
